### src/gyro_angle_kalman_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Gyro angle Kalman filter: assertion macros
// Clocked, reset-gated assertion wrappers used by the controller.
// ----------------------------------------------------------------------------
`ifndef GYRO_ANGLE_KALMAN_FILTER_CORE_MACROS_SVH
`define GYRO_ANGLE_KALMAN_FILTER_CORE_MACROS_SVH

// plain property, sampled on clk_i, off during reset
`define GAKF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication form: antecedent |-> consequent
`define GAKF_ASSERT_IMP(lbl, ante, cons, msg) \
  `GAKF_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### src/gakf_pkg.sv
// ----------------------------------------------------------------------------
// Gyro angle Kalman filter: package
// Shared constants, micro-op codes and fixed-point helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gakf_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int COV_FRAC_BITS_DEF   = 24;
  localparam int DT_FRAC_BITS        = 24;
  localparam int DIV_STEPS           = 33;

  // noise reset values in thousandths
  localparam longint NOISE_ANGLE_MILLI = 1;
  localparam longint NOISE_BIAS_MILLI  = 3;
  localparam longint NOISE_MEAS_MILLI  = 30;
  localparam longint ANGLE_RST_DEG     = 180;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_RATE,
    OP_MUL_ANG,
    OP_MUL_P11,
    OP_MUL_Q00,
    OP_MUL_Q11,
    OP_PREP,
    OP_DIV_K0,
    OP_DIV_K1,
    OP_MUL_ANGC,
    OP_MUL_BIAS,
    OP_MUL_C0,
    OP_MUL_C1,
    OP_MUL_C2,
    OP_MUL_C3,
    OP_SET,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // product >> sh, rounded to nearest, halves away from zero
  function automatic logic signed [69:0] mul_rnd(input logic signed [69:0] p,
                                                 input int unsigned sh);
    logic [69:0] m;
    m = p[69] ? (~p + 70'd1) : p;
    m = (m + (70'd1 << (sh - 1))) >> sh;
    return p[69] ? signed'(~m + 70'd1) : signed'(m);
  endfunction

  // sign and saturate an unsigned quotient
  function automatic logic signed [31:0] div_fin(input logic [32:0] q, input logic neg);
    logic signed [31:0] r;
    if (q >= 33'h0_8000_0000) begin
      r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = neg ? signed'(~q[31:0] + 32'd1) : signed'(q[31:0]);
    end
    return r;
  endfunction

endpackage

### src/gakf_ctrl.sv
// ----------------------------------------------------------------------------
// Gyro angle Kalman filter: controller
// Sequences the datapath micro-ops for one item and owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gyro_angle_kalman_filter_core_macros.svh"

module gakf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              opcode_i,
  input  logic              out_ready_i,
  input  gakf_pkg::status_t status_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output gakf_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_GAP,
    ST_HOLD,
    ST_OUT_WAIT,
    ST_OUT
  } state_e;

  state_e         state_q;
  gakf_pkg::op_e  op_q;
  gakf_pkg::cmd_t cmd_q;
  logic           out_valid_q;

  function automatic gakf_pkg::op_e next_op(input gakf_pkg::op_e op);
    gakf_pkg::op_e n;
    unique case (op)
      gakf_pkg::OP_RATE:     n = gakf_pkg::OP_MUL_ANG;
      gakf_pkg::OP_MUL_ANG:  n = gakf_pkg::OP_MUL_P11;
      gakf_pkg::OP_MUL_P11:  n = gakf_pkg::OP_MUL_Q00;
      gakf_pkg::OP_MUL_Q00:  n = gakf_pkg::OP_MUL_Q11;
      gakf_pkg::OP_MUL_Q11:  n = gakf_pkg::OP_PREP;
      gakf_pkg::OP_PREP:     n = gakf_pkg::OP_DIV_K0;
      gakf_pkg::OP_DIV_K0:   n = gakf_pkg::OP_DIV_K1;
      gakf_pkg::OP_DIV_K1:   n = gakf_pkg::OP_MUL_ANGC;
      gakf_pkg::OP_MUL_ANGC: n = gakf_pkg::OP_MUL_BIAS;
      gakf_pkg::OP_MUL_BIAS: n = gakf_pkg::OP_MUL_C0;
      gakf_pkg::OP_MUL_C0:   n = gakf_pkg::OP_MUL_C1;
      gakf_pkg::OP_MUL_C1:   n = gakf_pkg::OP_MUL_C2;
      gakf_pkg::OP_MUL_C2:   n = gakf_pkg::OP_MUL_C3;
      default:               n = gakf_pkg::OP_NONE;
    endcase
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= gakf_pkg::OP_NONE;
      cmd_q       <= '{op: gakf_pkg::OP_NONE};
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept_i) begin
            op_q    <= opcode_i ? gakf_pkg::OP_SET : gakf_pkg::OP_RATE;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          cmd_q   <= '{op: op_q};
          state_q <= ST_GAP;
        end
        ST_GAP: begin
          cmd_q   <= '{op: gakf_pkg::OP_NONE};
          state_q <= ST_HOLD;
        end
        ST_HOLD: begin
          // wait out the divider, then advance
          if (!status_i.div_busy) begin
            if (op_q == gakf_pkg::OP_SET || op_q == gakf_pkg::OP_MUL_C3) begin
              state_q <= ST_OUT_WAIT;
            end else begin
              op_q    <= next_op(op_q);
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_OUT_WAIT: begin
          if (!out_valid_q || out_ready_i) begin
            cmd_q   <= '{op: gakf_pkg::OP_OUT};
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          cmd_q       <= '{op: gakf_pkg::OP_NONE};
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd_q;

  `GAKF_ASSERT_IMP(a_cmd_pulse, cmd_q.op != gakf_pkg::OP_NONE, ##1 cmd_q.op == gakf_pkg::OP_NONE,
    "micro-op held longer than one cycle")
  `GAKF_ASSERT_IMP(a_idle_div, state_q == ST_IDLE, !status_i.div_busy,
    "divider busy while controller idle")
  `GAKF_ASSERT_IMP(a_out_rise, $rose(out_valid_q), $past(state_q == ST_OUT),
    "result raised outside the output step")

endmodule

### src/gakf_dp.sv
// ----------------------------------------------------------------------------
// Gyro angle Kalman filter: datapath
// Filter state, shared multiplier with rounding writeback, serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gakf_dp #(
  parameter int ANGLE_FRAC_BITS = gakf_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int COV_FRAC_BITS   = gakf_pkg::COV_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic signed [31:0] angle_sample_i,
  input  logic signed [31:0] rate_sample_i,
  input  logic [23:0]        elapsed_time_i,
  input  logic signed [31:0] new_angle_i,
  input  logic [30:0]        noise_angle_i,
  input  logic [30:0]        noise_bias_i,
  input  logic [30:0]        noise_meas_i,
  input  gakf_pkg::cmd_t     cmd_i,
  output gakf_pkg::status_t  status_o,
  output logic signed [31:0] angle_estimate_o,
  output logic signed [31:0] rate_estimate_o
);

  localparam int NW = 32 + COV_FRAC_BITS;
  localparam int CW = $clog2(gakf_pkg::DIV_STEPS + 1);
  localparam longint ANGLE_RAW = gakf_pkg::ANGLE_RST_DEG * (64'sd1 <<< ANGLE_FRAC_BITS);
  localparam logic signed [31:0] ANGLE_RST =
    (ANGLE_RAW > 64'sd2147483647) ? 32'sh7FFF_FFFF : 32'(ANGLE_RAW);

  // architectural state
  logic signed [31:0] angle_q, bias_q, rate_q;
  logic signed [31:0] p_q [4];

  // latched item
  logic signed [31:0] z_q, g_q, na_q;
  logic [23:0]        dt_q;

  // intermediates
  logic signed [31:0] angp_q, q00_q, q01_q, q10_q, q11_q, y_q, k0_q, k1_q;
  logic signed [34:0] inner_q;
  logic signed [32:0] s_q;
  logic signed [31:0] out_angle_q, out_rate_q;

  // multiplier
  logic signed [34:0] mul_a, mul_b, dt_s;
  logic signed [69:0] prod_q, rv;
  gakf_pkg::op_e      wb_op_q;
  logic               wb_dt;
  logic signed [71:0] inner_full;

  // divider
  logic [CW-1:0]      div_cnt_q;
  logic [33:0]        div_rem_q, rem2, rem_nx, rinit;
  logic [32:0]        div_lo_q, div_quo_q, div_d_q, quo_nx, div_ad;
  logic               div_neg_q, div_dst_q, ge, div_neg;
  logic signed [31:0] div_num;
  logic [31:0]        div_anum;
  logic [NW-1:0]      nfull;

  assign dt_s = signed'({11'd0, dt_q});

  always_comb begin
    case (cmd_i.op)
      gakf_pkg::OP_MUL_ANG:  begin mul_a = dt_s;          mul_b = 35'(rate_q); end
      gakf_pkg::OP_MUL_P11:  begin mul_a = dt_s;          mul_b = 35'(p_q[3]); end
      gakf_pkg::OP_MUL_Q00:  begin mul_a = dt_s;          mul_b = inner_q;     end
      gakf_pkg::OP_MUL_Q11:  begin
        mul_a = signed'({4'd0, noise_bias_i});
        mul_b = dt_s;
      end
      gakf_pkg::OP_MUL_ANGC: begin mul_a = 35'(k0_q);     mul_b = 35'(y_q);    end
      gakf_pkg::OP_MUL_BIAS: begin mul_a = 35'(k1_q);     mul_b = 35'(y_q);    end
      gakf_pkg::OP_MUL_C0:   begin mul_a = 35'(k0_q);     mul_b = 35'(q00_q);  end
      gakf_pkg::OP_MUL_C1:   begin mul_a = 35'(k0_q);     mul_b = 35'(q01_q);  end
      gakf_pkg::OP_MUL_C2:   begin mul_a = 35'(k1_q);     mul_b = 35'(q00_q);  end
      gakf_pkg::OP_MUL_C3:   begin mul_a = 35'(k1_q);     mul_b = 35'(q01_q);  end
      default:               begin mul_a = '0;            mul_b = '0;          end
    endcase
  end

  always_comb begin
    case (wb_op_q) inside
      gakf_pkg::OP_MUL_ANG, gakf_pkg::OP_MUL_P11,
      gakf_pkg::OP_MUL_Q00, gakf_pkg::OP_MUL_Q11: wb_dt = 1'b1;
      default:                                     wb_dt = 1'b0;
    endcase
    rv = wb_dt ? gakf_pkg::mul_rnd(prod_q, gakf_pkg::DT_FRAC_BITS)
               : gakf_pkg::mul_rnd(prod_q, COV_FRAC_BITS);
    inner_full = 72'(rv) - 72'(p_q[1]) - 72'(p_q[2]) + 72'(signed'({1'b0, noise_angle_i}));
  end

  // divider start operands and one restoring step
  always_comb begin
    div_num  = (cmd_i.op == gakf_pkg::OP_DIV_K1) ? q10_q : q00_q;
    div_anum = div_num[31] ? (~div_num + 32'd1) : div_num;
    div_ad   = s_q[32] ? (~s_q + 33'd1) : s_q;
    div_neg  = div_num[31] ^ s_q[32];
    nfull    = {div_anum, {COV_FRAC_BITS{1'b0}}};
    rinit    = 34'(nfull >> 33);
    rem2     = {div_rem_q[32:0], div_lo_q[32]};
    ge       = (rem2 >= {1'b0, div_d_q});
    rem_nx   = ge ? (rem2 - {1'b0, div_d_q}) : rem2;
    quo_nx   = {div_quo_q[31:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q   <= ANGLE_RST;
      bias_q    <= '0;
      rate_q    <= '0;
      p_q       <= '{default: '0};
      wb_op_q   <= gakf_pkg::OP_NONE;
      div_cnt_q <= '0;
    end else begin
      wb_op_q <= cmd_i.op;
      case (cmd_i.op)
        gakf_pkg::OP_RATE: rate_q  <= gakf_pkg::sat32(72'(g_q) - 72'(bias_q));
        gakf_pkg::OP_SET:  angle_q <= na_q;
        default: ;
      endcase
      case (wb_op_q)
        gakf_pkg::OP_MUL_ANGC: angle_q <= gakf_pkg::sat32(72'(angp_q) + 72'(rv));
        gakf_pkg::OP_MUL_BIAS: bias_q  <= gakf_pkg::sat32(72'(bias_q) + 72'(rv));
        gakf_pkg::OP_MUL_C0:   p_q[0]  <= gakf_pkg::sat32(72'(q00_q) - 72'(rv));
        gakf_pkg::OP_MUL_C1:   p_q[1]  <= gakf_pkg::sat32(72'(q01_q) - 72'(rv));
        gakf_pkg::OP_MUL_C2:   p_q[2]  <= gakf_pkg::sat32(72'(q10_q) - 72'(rv));
        gakf_pkg::OP_MUL_C3:   p_q[3]  <= gakf_pkg::sat32(72'(q11_q) - 72'(rv));
        default: ;
      endcase
      if (cmd_i.op == gakf_pkg::OP_DIV_K0 || cmd_i.op == gakf_pkg::OP_DIV_K1) begin
        if (div_ad != '0 && rinit < {1'b0, div_ad}) begin
          div_cnt_q <= CW'(gakf_pkg::DIV_STEPS);
        end
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      z_q  <= angle_sample_i;
      g_q  <= rate_sample_i;
      dt_q <= elapsed_time_i;
      na_q <= new_angle_i;
    end
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      gakf_pkg::OP_PREP: begin
        s_q <= 33'(q00_q) + 33'(signed'({1'b0, noise_meas_i}));
        y_q <= gakf_pkg::sat32(72'(z_q) - 72'(angp_q));
      end
      gakf_pkg::OP_OUT: begin
        out_angle_q <= angle_q;
        out_rate_q  <= rate_q;
      end
      gakf_pkg::OP_DIV_K0, gakf_pkg::OP_DIV_K1: begin
        div_dst_q <= (cmd_i.op == gakf_pkg::OP_DIV_K1);
        div_neg_q <= div_neg;
        div_d_q   <= div_ad;
        div_rem_q <= rinit;
        div_lo_q  <= nfull[32:0];
        div_quo_q <= '0;
        // zero divisor gives zero gain; an oversized quotient saturates
        if (div_ad == '0) begin
          if (cmd_i.op == gakf_pkg::OP_DIV_K1) k1_q <= '0;
          else                                 k0_q <= '0;
        end else if (rinit >= {1'b0, div_ad}) begin
          if (cmd_i.op == gakf_pkg::OP_DIV_K1) k1_q <= gakf_pkg::div_fin('1, div_neg);
          else                                 k0_q <= gakf_pkg::div_fin('1, div_neg);
        end
      end
      default: ;
    endcase
    if (div_cnt_q != '0) begin
      div_rem_q <= rem_nx;
      div_lo_q  <= {div_lo_q[31:0], 1'b0};
      div_quo_q <= quo_nx;
      if (div_cnt_q == CW'(1)) begin
        if (div_dst_q) k1_q <= gakf_pkg::div_fin(quo_nx, div_neg_q);
        else           k0_q <= gakf_pkg::div_fin(quo_nx, div_neg_q);
      end
    end
    case (wb_op_q)
      gakf_pkg::OP_MUL_ANG: angp_q <= gakf_pkg::sat32(72'(angle_q) + 72'(rv));
      gakf_pkg::OP_MUL_P11: begin
        q01_q   <= gakf_pkg::sat32(72'(p_q[1]) - 72'(rv));
        q10_q   <= gakf_pkg::sat32(72'(p_q[2]) - 72'(rv));
        inner_q <= inner_full[34:0];
      end
      gakf_pkg::OP_MUL_Q00: q00_q <= gakf_pkg::sat32(72'(p_q[0]) + 72'(rv));
      gakf_pkg::OP_MUL_Q11: q11_q <= gakf_pkg::sat32(72'(p_q[3]) + 72'(rv));
      default: ;
    endcase
  end

  assign status_o         = '{div_busy: (div_cnt_q != '0)};
  assign angle_estimate_o = out_angle_q;
  assign rate_estimate_o  = out_rate_q;

endmodule

### src/gyro_angle_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// Gyro angle Kalman filter core
// Two-state angle and gyro-bias filter with an APB register port.
//
// Input channel (in_valid_i / in_ready_o): one item per sample. opcode 0 runs
// a full predict and correct step from angle_sample, rate_sample and
// elapsed_time; opcode 1 loads new_angle into the angle estimate.
// Output channel (out_valid_o / out_ready_i): one result per item, the angle
// estimate and the unbiased rate after that item.
// Sequence: an update runs fourteen sequencer steps (ten of them passes through
// the one shared multiplier, two of them the serial gain divisions), then posts
// the result. A set item loads the angle and then posts the result.
// One item is in work at a time; in_ready_o is high while the sequencer is
// idle, so a new item is accepted only after the last one has posted its result.
// The result sits in an output register, so a new item is accepted while it
// waits; a stalled receiver holds back only the next result.
// Reset puts the angle at 180 degrees, bias, rate and covariance at zero, and
// the noise registers at 0.001, 0.003 and 0.03. APB registers at 0x0, 0x4
// and 0x8; write them only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gyro_angle_kalman_filter_core #(
  parameter int ANGLE_FRAC_BITS = gakf_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int COV_FRAC_BITS   = gakf_pkg::COV_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic signed [31:0] angle_sample_i,
  input  logic signed [31:0] rate_sample_i,
  input  logic [23:0]        elapsed_time_i,
  input  logic signed [31:0] new_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] angle_estimate_o,
  output logic signed [31:0] rate_estimate_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [1:0] REG_NOISE_ANGLE = 2'd0;
  localparam logic [1:0] REG_NOISE_BIAS  = 2'd1;
  localparam logic [1:0] REG_NOISE_MEAS  = 2'd2;

  localparam longint ONE_C = 64'sd1 <<< COV_FRAC_BITS;
  localparam logic [30:0] QA_RST = 31'((gakf_pkg::NOISE_ANGLE_MILLI * ONE_C + 500) / 1000);
  localparam logic [30:0] QB_RST = 31'((gakf_pkg::NOISE_BIAS_MILLI * ONE_C + 500) / 1000);
  localparam logic [30:0] R_RST  = 31'((gakf_pkg::NOISE_MEAS_MILLI * ONE_C + 500) / 1000);

  logic [30:0]       qa_q, qb_q, r_q;
  logic              wr_en, accept;
  gakf_pkg::cmd_t    cmd;
  gakf_pkg::status_t status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q <= QA_RST;
      qb_q <= QB_RST;
      r_q  <= R_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_NOISE_ANGLE: qa_q <= pwdata[30:0];
        REG_NOISE_BIAS:  qb_q <= pwdata[30:0];
        REG_NOISE_MEAS:  r_q  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NOISE_ANGLE: prdata = {1'b0, qa_q};
      REG_NOISE_BIAS:  prdata = {1'b0, qb_q};
      REG_NOISE_MEAS:  prdata = {1'b0, r_q};
      default:         prdata = '0;
    endcase
  end

  gakf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (opcode_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  gakf_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .COV_FRAC_BITS   (COV_FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept),
    .angle_sample_i   (angle_sample_i),
    .rate_sample_i    (rate_sample_i),
    .elapsed_time_i   (elapsed_time_i),
    .new_angle_i      (new_angle_i),
    .noise_angle_i    (qa_q),
    .noise_bias_i     (qb_q),
    .noise_meas_i     (r_q),
    .cmd_i            (cmd),
    .status_o         (status),
    .angle_estimate_o (angle_estimate_o),
    .rate_estimate_o  (rate_estimate_o)
  );

endmodule
